FILE: hdl/memory_load_checksum_assert.svh
// Assertion macros used by the checksum unit's checker.
`ifndef MEMORY_LOAD_CHECKSUM_ASSERT_SVH
`define MEMORY_LOAD_CHECKSUM_ASSERT_SVH

// Property checked on the rising clock edge while reset is released.
`define MLC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define MLC_ASSERT_NEXT(name, ante, cons) \
  `MLC_ASSERT(name, (ante) |=> (cons))

`endif

FILE: hdl/mlc_pkg.sv
// Package with the codes, sizes and CRC helper of the load checksum unit.
`default_nettype none

package mlc_pkg;

  typedef enum logic [1:0] {
    KindImem = 2'd0,
    KindDmem = 2'd1,
    KindSet  = 2'd2,
    KindRead = 2'd3
  } kind_e;

  localparam int unsigned IndexW = 15;
  localparam int unsigned DataW  = 32;

  // Memory sizes in words, one bit wider than an index so that 32768 fits.
  localparam logic [IndexW:0] ImemWords = 16'd4096;
  localparam logic [IndexW:0] DmemWords = 16'd1024;

  localparam logic [DataW-1:0] CrcPoly = 32'hEDB88320;

  // Reflected CRC-32 lookup entry for one byte value.
  function automatic logic [DataW-1:0] crc_table(input logic [7:0] idx);
    logic [DataW-1:0] s;
    s = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      if (s[0]) begin
        s = (s >> 1) ^ CrcPoly;
      end else begin
        s = s >> 1;
      end
    end
    return s;
  endfunction

  // Feeds one byte into a running (inverted) CRC register.
  function automatic logic [DataW-1:0] crc_byte(input logic [DataW-1:0] s,
                                                input logic [7:0]       b);
    return (s >> 8) ^ crc_table(s[7:0] ^ b);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/memory_load_checksum.sv
// Top level of the memory load checksum unit.
//
// Every word written to the instruction or data memory is presented on the
// input channel; the unit extends a running CRC-32 (IEEE, reflected) over the
// data word and a 16-bit tag made of the word index and a memory select bit.
// A checksum set word loads the register, a checksum read word leaves it.
// Each input word yields exactly one output word carrying the checksum after
// that word and a flag for a write index beyond the chosen memory.
// The input word is registered, the CRC update runs in one pass of logic, and
// the result lands in an output register; one word is taken per cycle while
// the output is not stalled.
// The loop through the checksum register sets that rate of one per cycle.
// When the receiver stalls a valid output word, the output holds and the
// input register fills; the input stalls only while both are occupied.
// Reset clears the checksum to zero and empties both registers.
`default_nettype none

module memory_load_checksum (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [1:0]                  in_kind_i,
  input  wire logic [mlc_pkg::IndexW-1:0]  in_word_index_i,
  input  wire logic [mlc_pkg::DataW-1:0]   in_write_data_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [mlc_pkg::DataW-1:0]   out_read_data_o,
  output      logic                        out_range_error_o
);
  import mlc_pkg::*;

  logic              s1_valid_q;
  logic [1:0]        s1_kind_q;
  logic [IndexW-1:0] s1_index_q;
  logic [DataW-1:0]  s1_data_q;

  logic              out_valid_q;
  logic [DataW-1:0]  out_data_q;
  logic              out_err_q;

  logic [DataW-1:0]  checksum_q;
  logic [DataW-1:0]  checksum_d;
  logic              err_d;

  logic              in_accept;
  logic              s1_advance;
  logic              out_free;

  logic              is_imem;
  logic              is_write;
  logic              in_range;
  logic [15:0]       tag;
  logic [DataW-1:0]  crc_s;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    is_imem  = (s1_kind_q == KindImem);
    is_write = is_imem || (s1_kind_q == KindDmem);
    if (is_imem) begin
      in_range = {1'b0, s1_index_q} < ImemWords;
    end else begin
      in_range = {1'b0, s1_index_q} < DmemWords;
    end
    tag   = {is_imem, s1_index_q};
    crc_s = ~checksum_q;
    crc_s = crc_byte(crc_s, s1_data_q[7:0]);
    crc_s = crc_byte(crc_s, s1_data_q[15:8]);
    crc_s = crc_byte(crc_s, s1_data_q[23:16]);
    crc_s = crc_byte(crc_s, s1_data_q[31:24]);
    crc_s = crc_byte(crc_s, tag[7:0]);
    crc_s = crc_byte(crc_s, tag[15:8]);

    checksum_d = checksum_q;
    err_d      = 1'b0;
    if (is_write) begin
      if (in_range) begin
        checksum_d = ~crc_s;
      end else begin
        err_d = 1'b1;
      end
    end else if (s1_kind_q == KindSet) begin
      checksum_d = s1_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      checksum_q  <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
        checksum_q  <= checksum_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q  <= in_kind_i;
      s1_index_q <= in_word_index_i;
      s1_data_q  <= in_write_data_i;
    end
    if (s1_advance) begin
      out_data_q <= checksum_d;
      out_err_q  <= err_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_read_data_o   = out_data_q;
  assign out_range_error_o = out_err_q;

endmodule

`default_nettype wire

FILE: hdl/mlc_checker.sv
// Port-level checker for the memory load checksum unit and its binding.
`default_nettype none
`include "memory_load_checksum_assert.svh"

module mlc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic [1:0]                  in_kind_i,
  input wire logic [mlc_pkg::IndexW-1:0]  in_word_index_i,
  input wire logic [mlc_pkg::DataW-1:0]   in_write_data_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [mlc_pkg::DataW-1:0]   out_read_data_o,
  input wire logic                        out_range_error_o
);
  import mlc_pkg::*;

  // A stalled output word holds.
  `MLC_ASSERT_NEXT(out_hold_a, out_valid_o && out_stall_i, out_valid_o && $stable(out_read_data_o) && $stable(out_range_error_o))

  // The input stalls only because a full output word is held back.
  `MLC_ASSERT(in_stall_cause_a, in_stall_o |-> (out_valid_o && out_stall_i))

  // A checksum set shows its value through the input and output registers when the output moves.
  `MLC_ASSERT(set_value_a, (in_valid_i && !in_stall_o && in_kind_i == KindSet) ##1 !(out_valid_o && out_stall_i) |=> (out_valid_o && !out_range_error_o && out_read_data_o == $past(in_write_data_i, 2)))

  // An instruction write beyond the memory is flagged.
  `MLC_ASSERT(imem_range_a, (in_valid_i && !in_stall_o && in_kind_i == KindImem && {1'b0, in_word_index_i} >= ImemWords) ##1 !(out_valid_o && out_stall_i) |=> (out_valid_o && out_range_error_o))

endmodule

bind memory_load_checksum mlc_checker u_mlc_checker (.*);

`default_nettype wire
